/* rtl/lmpc_pkg.sv */
// ----------------------------------------------------------------------------
// lmpc_pkg
// Shared constants, codes and types for the LCG memory pattern checker.
// ----------------------------------------------------------------------------
package lmpc_pkg;

  // Generator step: x = x * LCG_MUL + LCG_ADD (mod 2^32)
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  // Generator value one step after an all-zero word
  localparam logic [31:0] LCG_FROM_ZERO = LCG_ADD;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 27;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_W   = 2;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

  // Element size modes
  localparam logic [MODE_W-1:0] MODE_WORD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_SEED          = 2'd0;
  localparam logic [CFG_W-1:0] CFG_WIDTH_MODE    = 2'd1;
  localparam logic [CFG_W-1:0] CFG_ELEMENT_COUNT = 2'd2;

  localparam logic [INDEX_W-1:0] ELEMENT_COUNT_RESET = 27'd1;

  // Generator control from the tracker
  typedef struct packed {
    logic restart;  // reload from seed
    logic advance;  // take the stepped word
  } lcg_ctl_t;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] error_count;
    logic              mismatch;
    logic [WORD_W-1:0] pattern_element;
    logic              last;
  } result_t;

endpackage

/* rtl/lmpc_lcg.sv */
// ----------------------------------------------------------------------------
// lmpc_lcg
// Linear congruential generator with a one-step lookahead register, so the
// stepped word is always ready and the multiplier runs register to register.
// ----------------------------------------------------------------------------
module lmpc_lcg (
  input  logic                      clk,
  input  logic                      rst,
  input  lmpc_pkg::lcg_ctl_t        ctl,
  input  logic [lmpc_pkg::WORD_W-1:0] seed,
  output logic [lmpc_pkg::WORD_W-1:0] gen_word,
  output logic [lmpc_pkg::WORD_W-1:0] gen_step
);
  import lmpc_pkg::*;

  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] lcg_out;

  // Step either the fresh seed or the lookahead word
  assign operand = ctl.restart ? seed : gen_step;
  assign lcg_out = WORD_W'(operand * LCG_MUL + LCG_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_word <= '0;
      gen_step <= LCG_FROM_ZERO;
    end else if (ctl.restart) begin
      gen_word <= seed;
      gen_step <= lcg_out;
    end else if (ctl.advance) begin
      gen_word <= gen_step;
      gen_step <= lcg_out;
    end
  end

endmodule

/* rtl/lmpc_track.sv */
// ----------------------------------------------------------------------------
// lmpc_track
// Chunk selection, read-data compare, run position and error counting for
// one item per cycle while fire is set. Drives the generator control.
// ----------------------------------------------------------------------------
module lmpc_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [lmpc_pkg::KIND_W-1:0]  kind,
  input  logic [lmpc_pkg::WORD_W-1:0]  read_data,
  input  logic [lmpc_pkg::MODE_W-1:0]  width_mode,
  input  logic [lmpc_pkg::INDEX_W-1:0] element_count,
  input  logic [lmpc_pkg::WORD_W-1:0]  gen_word,
  input  logic [lmpc_pkg::WORD_W-1:0]  gen_step,
  output lmpc_pkg::lcg_ctl_t           ctl,
  output lmpc_pkg::result_t            result
);
  import lmpc_pkg::*;

  // State
  logic [1:0]         chunk_position;
  logic [INDEX_W-1:0] element_index;
  logic [WORD_W-1:0]  mismatch_total;

  logic [1:0]         chunk_position_next;
  logic [INDEX_W-1:0] element_index_next;
  logic [WORD_W-1:0]  mismatch_total_next;

  logic [1:0]         chunk_max;
  logic               need_step;
  logic [WORD_W-1:0]  cur_word;
  logic [1:0]         eff_pos;
  logic [WORD_W-1:0]  elem;
  logic [WORD_W-1:0]  rd_masked;
  logic [INDEX_W-1:0] count_m1;
  logic               is_elem;
  logic               miss;
  logic               last_hit;

  // Chunk pick: step the generator at a word boundary or after a mode shrink
  always_comb begin
    case (width_mode)
      MODE_HALF: chunk_max = 2'd1;
      MODE_BYTE: chunk_max = 2'd3;
      default:   chunk_max = 2'd0;
    endcase
    need_step = (chunk_position == 2'd0) || (chunk_position > chunk_max);
    cur_word  = need_step ? gen_step : gen_word;
    eff_pos   = need_step ? 2'd0 : chunk_position;

    case (width_mode)
      MODE_HALF: begin
        elem      = eff_pos[0] ? {16'b0, cur_word[15:0]} : {16'b0, cur_word[31:16]};
        rd_masked = {16'b0, read_data[15:0]};
      end
      MODE_BYTE: begin
        case (eff_pos)
          2'd0:    elem = {24'b0, cur_word[31:24]};
          2'd1:    elem = {24'b0, cur_word[23:16]};
          2'd2:    elem = {24'b0, cur_word[15:8]};
          default: elem = {24'b0, cur_word[7:0]};
        endcase
        rd_masked = {24'b0, read_data[7:0]};
      end
      default: begin
        elem      = cur_word;
        rd_masked = read_data;
      end
    endcase
  end

  // Item decode, counters and result
  always_comb begin
    is_elem  = (kind == KIND_WRITE) || (kind == KIND_CHECK);
    count_m1 = element_count - INDEX_W'(1);
    last_hit = (element_index == count_m1);
    miss     = (kind == KIND_CHECK) && (rd_masked != elem);

    chunk_position_next = chunk_position;
    element_index_next  = element_index;
    mismatch_total_next = mismatch_total;

    if (kind == KIND_RESTART) begin
      chunk_position_next = '0;
      element_index_next  = '0;
      mismatch_total_next = '0;
    end else if (is_elem) begin
      chunk_position_next = (eff_pos == chunk_max) ? 2'd0 : eff_pos + 2'd1;
      element_index_next  = last_hit ? '0 : element_index + INDEX_W'(1);
      if (miss && (mismatch_total != '1)) begin
        mismatch_total_next = mismatch_total + WORD_W'(1);
      end
    end

    ctl.restart = fire && (kind == KIND_RESTART);
    ctl.advance = fire && is_elem && need_step;

    result.pattern_element = is_elem ? elem : '0;
    result.mismatch        = is_elem && miss;
    result.error_count     = mismatch_total_next;
    result.last            = is_elem && last_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_position <= '0;
      element_index  <= '0;
      mismatch_total <= '0;
    end else if (fire) begin
      chunk_position <= chunk_position_next;
      element_index  <= element_index_next;
      mismatch_total <= mismatch_total_next;
    end
  end

endmodule

/* rtl/lcg_memory_pattern_checker_core.sv */
// ----------------------------------------------------------------------------
// lcg_memory_pattern_checker_core
// Memory self-test pattern engine: LCG pattern generation, read-back check
// and saturating error count, one element per transaction.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                       Contents
//  s_*       in   s_tvalid/s_tready/s_tdata/    read_data, kind
//                 s_tuser
//  m_*       out  m_tvalid/m_tready/m_tdata/    pattern_element, mismatch,
//                 m_tlast                       error_count, last
//  cfg_*     in   cfg_we/cfg_index/cfg_data     seed, width_mode, element_count
//
//  One item per cycle sustained unless the output stalls; each input
//  transaction passes the input register, then the result register.
//  The loop through the generator lookahead multiply and the chunk counters
//  closes between registers, so consecutive items follow without gaps.
//  A stalled output holds its result while one more item waits in the input
//  register. Synchronous reset clears control state and config registers.
// ----------------------------------------------------------------------------
module lcg_memory_pattern_checker_core (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lmpc_pkg::WORD_W-1:0]  s_tdata,   // [31:0] read_data
  input  logic [lmpc_pkg::KIND_W-1:0]  s_tuser,   // [1:0] kind
  // Result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [71:0]                  m_tdata,   // [31:0] pattern_element,
                                                  // [32] mismatch,
                                                  // [64:33] error_count, pad
  output logic                         m_tlast,   // last element of run
  // Configuration writes
  input  logic                         cfg_we,
  input  logic [lmpc_pkg::CFG_W-1:0]   cfg_index,
  input  logic [lmpc_pkg::WORD_W-1:0]  cfg_data
);
  import lmpc_pkg::*;

  // Configuration registers
  logic [WORD_W-1:0]  seed;
  logic [MODE_W-1:0]  width_mode;
  logic [INDEX_W-1:0] element_count;

  // Input register
  logic               in_valid;
  logic [KIND_W-1:0]  in_kind;
  logic [WORD_W-1:0]  in_data;

  // Result register
  result_t            res;
  result_t            res_next;

  lcg_ctl_t           ctl;
  logic [WORD_W-1:0]  gen_word;
  logic [WORD_W-1:0]  gen_step;
  logic               fire;

  // Config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      seed          <= '0;
      width_mode    <= MODE_WORD;
      element_count <= ELEMENT_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED:          seed          <= cfg_data;
        CFG_WIDTH_MODE:    width_mode    <= cfg_data[MODE_W-1:0];
        CFG_ELEMENT_COUNT: element_count <= cfg_data[INDEX_W-1:0];
        default:           ;
      endcase
    end
  end

  // Handshake: item moves on when the result register is free
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_data <= s_tdata;
    end
  end

  lmpc_lcg u_lcg (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .seed     (seed),
    .gen_word (gen_word),
    .gen_step (gen_step)
  );

  lmpc_track u_track (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .kind          (in_kind),
    .read_data     (in_data),
    .width_mode    (width_mode),
    .element_count (element_count),
    .gen_word      (gen_word),
    .gen_step      (gen_step),
    .ctl           (ctl),
    .result        (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = {7'b0, res.error_count, res.mismatch, res.pattern_element};
  assign m_tlast = res.last;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lcg_memory_pattern_checker_core. A scoreboard class
// keeps its own LCG, chunk and run counters, predicts every result, and
// checks the result stream in order. Directed items come first, then random
// restart/write/check runs under three sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import lmpc_pkg::*;

  // Kind code and mode value outside the named set
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [WORD_W-1:0]  FULL_MASK  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0]  HALF_MASK  = 32'h0000_FFFF;
  localparam logic [WORD_W-1:0]  BYTE_MASK  = 32'h0000_00FF;
  localparam logic [INDEX_W-1:0] COUNT_MAX  = 27'h7FF_FFFF;
  localparam logic [INDEX_W-1:0] COUNT_HIGH = 27'd67108864;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int ITEMS_PER_SET = 384;

  // One predicted result
  typedef struct {
    logic [WORD_W-1:0] element;
    logic              mismatch;
    logic [WORD_W-1:0] errors;
    logic              last;
  } pattern_result_t;

  // --------------------------------------------------------------------------
  // Pattern predictor and expected-result store
  // --------------------------------------------------------------------------
  class pattern_scoreboard;
    logic [WORD_W-1:0]  seed;
    logic [MODE_W-1:0]  width_mode;
    logic [INDEX_W-1:0] element_count;
    logic [WORD_W-1:0]  lcg_word;
    logic [1:0]         chunk_pos;
    logic [INDEX_W-1:0] run_index;
    logic [WORD_W-1:0]  miss_total;
    pattern_result_t    expected_results[$];
    int                 errors;

    function new();
      seed          = '0;
      width_mode    = MODE_WORD;
      element_count = ELEMENT_COUNT_RESET;
      lcg_word      = '0;
      chunk_pos     = '0;
      run_index     = '0;
      miss_total    = '0;
      errors        = 0;
    endfunction

    function void set_reg(logic [CFG_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        CFG_SEED:          seed = data;
        CFG_WIDTH_MODE:    width_mode = data[MODE_W-1:0];
        CFG_ELEMENT_COUNT: element_count = data[INDEX_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned chunks();
      if (width_mode == MODE_HALF) return 2;
      if (width_mode == MODE_BYTE) return 4;
      return 1;
    endfunction

    function logic [WORD_W-1:0] element_mask();
      if (width_mode == MODE_HALF) return HALF_MASK;
      if (width_mode == MODE_BYTE) return BYTE_MASK;
      return FULL_MASK;
    endfunction

    // Next element; state moves only when commit is set
    function logic [WORD_W-1:0] next_chunk(bit commit);
      int unsigned       n;
      int unsigned       pos;
      int unsigned       shift;
      logic [WORD_W-1:0] word;
      n    = chunks();
      pos  = 32'(chunk_pos);
      word = lcg_word;
      // step the generator at the start of a word, or when the mode shrank
      if (pos == 0 || pos >= n) begin
        word = word * LCG_MUL + LCG_ADD;
        pos  = 0;
      end
      shift = (n - 1 - pos) * (WORD_W / n);
      if (commit) begin
        lcg_word  = word;
        chunk_pos = (pos + 1 >= n) ? 2'd0 : 2'(pos + 1);
      end
      return (word >> shift) & element_mask();
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] data);
      pattern_result_t r;
      r.element  = '0;
      r.mismatch = 1'b0;
      r.last     = 1'b0;
      if (kind == KIND_RESTART) begin
        lcg_word   = seed;
        chunk_pos  = '0;
        run_index  = '0;
        miss_total = '0;
      end else if (kind == KIND_WRITE || kind == KIND_CHECK) begin
        r.element = next_chunk(1'b1);
        if (kind == KIND_CHECK && (data & element_mask()) != r.element) begin
          r.mismatch = 1'b1;
          if (miss_total != FULL_MASK) miss_total++;
        end
        // end of run; count zero wraps to a full 2^27 run
        if (run_index == element_count - 27'd1) begin
          r.last    = 1'b1;
          run_index = '0;
        end else begin
          run_index = run_index + 27'd1;
        end
      end
      r.errors = miss_total;
      expected_results.push_back(r);
    endfunction

    function void check_element(logic [WORD_W-1:0] element, logic mismatch,
                                logic [WORD_W-1:0] errs, logic last);
      pattern_result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, element %h", $time, element);
        errors++;
        return;
      end
      r = expected_results.pop_front();
      if (element !== r.element) begin
        $display("%0t: pattern_element expected %h actual %h", $time, r.element, element);
        errors++;
      end
      if (mismatch !== r.mismatch) begin
        $display("%0t: mismatch expected %b actual %b", $time, r.mismatch, mismatch);
        errors++;
      end
      if (errs !== r.errors) begin
        $display("%0t: error_count expected %h actual %h", $time, r.errors, errs);
        errors++;
      end
      if (last !== r.last) begin
        $display("%0t: last expected %b actual %b", $time, r.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [WORD_W-1:0]   s_tdata = '0;
  logic [KIND_W-1:0]   s_tuser = KIND_NONE;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [71:0]         m_tdata;
  logic                m_tlast;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_index = CFG_SEED;
  logic [WORD_W-1:0]   cfg_data = '0;

  pattern_scoreboard   tracker = new();
  int                  tx_idle = 23;
  int                  rx_idle = 86;
  int                  items_sent = 0;
  int                  cycles = 0;

  lcg_memory_pattern_checker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_element(m_tdata[31:0], m_tdata[32], m_tdata[64:33], m_tlast);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_item(kind, data);
    items_sent++;
  endtask

  // Stop sending and let every result come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Caller lowers cfg_we after the last write
  task automatic write_reg(logic [CFG_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  // Read data for a check: mostly right, with junk above the element width
  function automatic logic [WORD_W-1:0] read_back();
    logic [WORD_W-1:0] elem;
    logic [WORD_W-1:0] mask;
    int                pick;
    elem = tracker.next_chunk(1'b0);
    mask = tracker.element_mask();
    pick = $urandom_range(0, 99);
    if (pick < 6) return elem ^ (32'd1 << $urandom_range(0, 31));
    if (pick < 10) return $urandom;
    return ($urandom & ~mask) | elem;
  endfunction

  task automatic configure_random(bit write_all);
    logic [WORD_W-1:0]  data;
    logic [INDEX_W-1:0] count;
    int                 pick;
    if (write_all || $urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, 9);
      data = (pick == 0) ? '0 : (pick == 1) ? FULL_MASK : $urandom;
      write_reg(CFG_SEED, data);
    end
    if (write_all || $urandom_range(0, 9) < 6) begin
      data = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) data = data | ($urandom & 32'hFFFF_FFFC);
      write_reg(CFG_WIDTH_MODE, data);
    end
    if (write_all || $urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      count = '0;
      else if (pick == 1) count = COUNT_MAX;
      else if (pick == 2) count = COUNT_HIGH;
      else                count = INDEX_W'($urandom_range(1, 12));
      data = {5'd0, count};
      if ($urandom_range(0, 3) == 0) data = data | ($urandom & 32'hF800_0000);
      write_reg(CFG_ELEMENT_COUNT, data);
    end
    cfg_we <= 1'b0;
  endtask

  // One random phase: new settings, then mostly write/check test runs
  task automatic run_phase(bit write_all);
    int target_len;
    int done;
    int len;
    drain();
    configure_random(write_all);
    target_len = $urandom_range(30, 60);
    done = 0;
    while (done < target_len) begin
      if ($urandom_range(0, 99) < 75) begin
        if (tracker.element_count != 0 && tracker.element_count <= 16 &&
            $urandom_range(0, 1) == 1)
          len = int'(tracker.element_count);
        else
          len = $urandom_range(1, 16);
        send_item(KIND_RESTART, $urandom);
        repeat (len) send_item(KIND_WRITE, $urandom);
        send_item(KIND_RESTART, $urandom);
        repeat (len) send_item(KIND_CHECK, read_back());
        done += 2 + 2 * len;
      end else begin
        send_item(KIND_W'($urandom_range(0, 3)), $urandom);
        done++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: generator from zero, one-element runs
    send_item(KIND_WRITE, $urandom);
    send_item(KIND_CHECK, tracker.next_chunk(1'b0));
    send_item(KIND_NONE, FULL_MASK);
    send_item(KIND_RESTART, '0);
    send_item(KIND_CHECK, ~tracker.next_chunk(1'b0));
    send_item(KIND_CHECK, '0);

    // Half mode, all-ones seed, three-element run
    drain();
    write_reg(CFG_SEED, FULL_MASK);
    write_reg(CFG_WIDTH_MODE, WORD_W'(MODE_HALF));
    write_reg(CFG_ELEMENT_COUNT, 32'd3);
    cfg_we <= 1'b0;
    send_item(KIND_RESTART, FULL_MASK);
    repeat (3) send_item(KIND_WRITE, '0);
    send_item(KIND_CHECK, 32'hFFFF_0000 | tracker.next_chunk(1'b0));
    send_item(KIND_CHECK, tracker.next_chunk(1'b0) ^ 32'd1);
    send_item(KIND_CHECK, tracker.next_chunk(1'b0));

    // Byte mode entered at a word boundary, count zero as a full-size run
    drain();
    write_reg(CFG_WIDTH_MODE, WORD_W'(MODE_BYTE));
    write_reg(CFG_ELEMENT_COUNT, 32'd0);
    cfg_we <= 1'b0;
    send_item(KIND_WRITE, '0);
    send_item(KIND_WRITE, '0);

    // Spare mode acts as word mode; count of 2^26
    drain();
    write_reg(CFG_WIDTH_MODE, WORD_W'(MODE_SPARE));
    write_reg(CFG_ELEMENT_COUNT, WORD_W'(COUNT_HIGH));
    cfg_we <= 1'b0;
    send_item(KIND_WRITE, '0);
    send_item(KIND_CHECK, tracker.next_chunk(1'b0));
    send_item(KIND_RESTART, '0);
    send_item(KIND_WRITE, '0);

    // Zero seed, byte mode, all-ones count with junk above the field
    drain();
    write_reg(CFG_SEED, '0);
    write_reg(CFG_WIDTH_MODE, WORD_W'(MODE_BYTE));
    write_reg(CFG_ELEMENT_COUNT, 32'hF800_0000 | WORD_W'(COUNT_MAX));
    cfg_we <= 1'b0;
    send_item(KIND_RESTART, '0);
    repeat (4) send_item(KIND_CHECK, 32'hFFFF_FF00 | tracker.next_chunk(1'b0));
    send_item(KIND_CHECK, ~tracker.next_chunk(1'b0));

    // Random phases under each idle pattern
    target = items_sent;
    for (int set = 0; set < 3; set++) begin
      if (set == 0) begin
        tx_idle = 23;
        rx_idle = 86;
      end else if (set == 1) begin
        tx_idle = 86;
        rx_idle = 23;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      target += ITEMS_PER_SET;
      run_phase(set == 0);
      while (items_sent < target) run_phase(1'b0);
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lmpc_pkg.sv
rtl/lmpc_lcg.sv
rtl/lmpc_track.sv
rtl/lcg_memory_pattern_checker_core.sv
sim/tb.sv
